[src/bmpd_pkg.sv]
// Package for the button multi-press detector: phase and event codes,
// register indexes, counter widths and small helper functions. No dependencies.
package bmpd_pkg;

   localparam int CntBits = 10;
   localparam int RegBits = 10;
   localparam int PressBits = 4;
   localparam int CmpBits = (CntBits > RegBits) ? CntBits : RegBits;

   typedef logic [CntBits-1:0] cnt_type;
   typedef logic [RegBits-1:0] reg_type;
   typedef logic [PressBits-1:0] press_type;

   localparam cnt_type CntMax = {CntBits{1'b1}};
   localparam press_type PressMax = {PressBits{1'b1}};

   typedef enum logic [1:0] {
      PH_WAIT_PRESS   = 2'd0,
      PH_PRESS_DB     = 2'd1,
      PH_WAIT_RELEASE = 2'd2,
      PH_RELEASE_DB   = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      EV_NONE          = 4'd0,
      EV_PRESS         = 4'd1,
      EV_DOUBLE        = 4'd2,
      EV_TRIPLE        = 4'd3,
      EV_MORE          = 4'd4,
      EV_RELEASED      = 4'd5,
      EV_DOUBLE_REL    = 4'd6,
      EV_TRIPLE_REL    = 4'd7,
      EV_MORE_REL      = 4'd8,
      EV_HOLD          = 4'd9,
      EV_HOLD_RELEASED = 4'd10
   } event_type;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE    = 2'd0,
      CSR_RELEASE_GAP = 2'd1,
      CSR_HOLD        = 2'd2
   } csr_index_type;

   function automatic cnt_type sat_inc(cnt_type v);
      return (v == CntMax) ? v : v + cnt_type'(1);
   endfunction

   function automatic logic cnt_ge(cnt_type a, reg_type b);
      logic [CmpBits-1:0] ax;
      logic [CmpBits-1:0] bx;
      ax = CmpBits'(a);
      bx = CmpBits'(b);
      return ax >= bx;
   endfunction

   // base + (single, double, triple, more) offset of a nonzero press count
   function automatic event_type count_event(event_type base, press_type n);
      logic [1:0] off;
      off = (n >= press_type'(4)) ? 2'd3 : 2'(n - press_type'(1));
      return event_type'(4'(base) + 4'(off));
   endfunction

endpackage

[src/button_multi_press_detector.sv]
// Button multi-press detector top level: debounce state machine, press
// counting, hold detection and a two-entry result buffer. Uses bmpd_pkg.
//
//  channel  | dir | handshake             | payload
//  req_     | in  | req_tvalid/req_tready | tdata[0] button_down, tuser restart
//  rsp_     | out | rsp_tvalid/rsp_tready | tdata[3:0] event_code
//  csr_     | in  | csr_we (no wait)      | csr_index, csr_wdata[9:0]
//
// One request per cycle while req_tready is high; each request yields one response.
// The detector state updates in the same cycle the request is accepted.
// A main output register plus a skid register take a new request while a
// response waits; req_tready drops only when both are full.
// Synchronous reset restores register defaults and the wait-for-press phase.
module button_multi_press_detector (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [0] button_down
   input  logic                   req_tuser,   // [0] restart
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [3:0] event_code
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [bmpd_pkg::RegBits-1:0] csr_wdata
);
   import bmpd_pkg::*;

   reg_type   debounce_ff, release_gap_ff, hold_ticks_ff;
   phase_type phase_ff, phase_in;
   logic      held_ff, held_in;
   cnt_type   hold_cnt_ff, hold_cnt_in;
   cnt_type   db_cnt_ff, db_cnt_in;
   cnt_type   gap_cnt_ff, gap_cnt_in;
   press_type press_ff, press_in;
   event_type ev;

   logic      out_valid_ff, skid_valid_ff;
   event_type out_ev_ff, skid_ev_ff;

   logic down, restart, accept, out_free;

   assign down    = req_tdata[0];
   assign restart = req_tuser;
   assign req_tready = !skid_valid_ff;
   assign accept  = req_tvalid && req_tready;
   assign out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, 4'(out_ev_ff)};

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= reg_type'(5);
         release_gap_ff <= reg_type'(50);
         hold_ticks_ff  <= reg_type'(200);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:    debounce_ff    <= csr_wdata;
            CSR_RELEASE_GAP: release_gap_ff <= csr_wdata;
            CSR_HOLD:        hold_ticks_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (restart) begin
         phase_in = down ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
      end else begin
         case (phase_ff)
            PH_WAIT_PRESS: begin
               if (down) phase_in = PH_PRESS_DB;
            end
            PH_PRESS_DB: begin
               if (!down) phase_in = PH_WAIT_PRESS;
               else if (cnt_ge(sat_inc(db_cnt_ff), debounce_ff)) phase_in = PH_WAIT_RELEASE;
            end
            PH_WAIT_RELEASE: begin
               if (!down) phase_in = PH_RELEASE_DB;
            end
            PH_RELEASE_DB: begin
               if (down) phase_in = PH_WAIT_RELEASE;
               else if (cnt_ge(sat_inc(db_cnt_ff), debounce_ff)) phase_in = PH_WAIT_PRESS;
            end
            default: phase_in = PH_WAIT_PRESS;
         endcase
      end
   end

   // counters and event
   always_comb begin
      held_in     = held_ff;
      hold_cnt_in = hold_cnt_ff;
      db_cnt_in   = db_cnt_ff;
      gap_cnt_in  = gap_cnt_ff;
      press_in    = press_ff;
      ev          = EV_NONE;
      if (restart) begin
         held_in     = 1'b0;
         hold_cnt_in = '0;
         db_cnt_in   = '0;
         gap_cnt_in  = '0;
         press_in    = '0;
      end else begin
         case (phase_ff)
            PH_WAIT_PRESS: begin
               gap_cnt_in = sat_inc(gap_cnt_ff);
               if (down) begin
                  db_cnt_in = '0;
               end else if (!cnt_ge(release_gap_ff, gap_cnt_in)) begin
                  if (held_ff) begin
                     held_in = 1'b0;
                     ev = EV_HOLD_RELEASED;
                  end else if (press_ff != '0) begin
                     ev = count_event(EV_RELEASED, press_ff);
                  end
                  press_in = '0;
               end
            end
            PH_PRESS_DB: begin
               db_cnt_in  = sat_inc(db_cnt_ff);
               gap_cnt_in = sat_inc(gap_cnt_ff);
               if (down && cnt_ge(db_cnt_in, debounce_ff)) begin
                  if (press_ff != PressMax) press_in = press_ff + press_type'(1);
                  ev = count_event(EV_PRESS, press_in);
                  hold_cnt_in = '0;
               end
            end
            PH_WAIT_RELEASE: begin
               hold_cnt_in = sat_inc(hold_cnt_ff);
               if (down) begin
                  if (press_ff < press_type'(2) && !held_ff &&
                      cnt_ge(hold_cnt_in, hold_ticks_ff)) begin
                     held_in = 1'b1;
                     ev = EV_HOLD;
                  end
               end else begin
                  db_cnt_in = '0;
               end
            end
            default: begin
               db_cnt_in = sat_inc(db_cnt_ff);
               if (!down && cnt_ge(db_cnt_in, debounce_ff)) gap_cnt_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT_PRESS;
         held_ff     <= 1'b0;
         hold_cnt_ff <= '0;
         db_cnt_ff   <= '0;
         gap_cnt_ff  <= '0;
         press_ff    <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         hold_cnt_ff <= hold_cnt_in;
         db_cnt_ff   <= db_cnt_in;
         gap_cnt_ff  <= gap_cnt_in;
         press_ff    <= press_in;
      end
   end

   // response register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) out_ev_ff <= skid_ev_ff;
         else if (accept)   out_ev_ff <= ev;
      end else if (accept) begin
         skid_ev_ff <= ev;
      end
   end

endmodule
